// ===== sv/pt_pkg.sv =====
// ----------------------------------------------------------------------------
// pt_pkg: shared types for the primality tester
// Holds the one-hot sequencer state type of the trial division engine.
// ----------------------------------------------------------------------------
package pt_pkg;

  // Sequencer states, one-hot coded.
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CHECK  = 3'b010,
    ST_DIVIDE = 3'b100
  } state_t;

endpackage

// ===== sv/primality_tester.sv =====
// ----------------------------------------------------------------------------
// primality_tester: trial division primality test
// Reports whether an unsigned WIDTH-bit candidate is prime. Odd trial divisors
// from 3 upward are tried until one divides the candidate or its square
// exceeds the candidate. Each remainder comes from one shared restoring
// subtractor, one quotient bit per cycle.
//
//   channel   signals                    direction  handshake
//   command   start, candidate, busy     in         start && !busy
//   result    done, prime_flag           out        done, one cycle, no stall
//
// A candidate below four, or an even one, answers in the cycle after start.
// An odd candidate n tries up to about (floor(sqrt(n)) - 1) / 2 trial divisors,
// each of WIDTH shift-subtract steps plus one square check, as set by the
// bit-serial remainder loop.
// rst is synchronous and active high; it returns the sequencer to idle.
// busy is high while a transaction is in work; the result cannot be stalled.
// ----------------------------------------------------------------------------
module primality_tester
  import pt_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] candidate,
  output logic             busy,
  output logic             done,
  output logic             prime_flag
);

  // Divisor width: the divisor ends just above sqrt(2^WIDTH).
  localparam int DW = (WIDTH + 1) / 2 + 2;
  // Square width: the running square may pass 2^WIDTH once.
  localparam int SW = WIDTH + 2;
  // Bit counter width.
  localparam int CW = $clog2(WIDTH);

  localparam logic [DW-1:0] FIRST_DIV = DW'(3);
  localparam logic [DW-1:0] DIV_STEP  = DW'(2);
  localparam logic [SW-1:0] FIRST_SQ  = SW'(9);
  localparam logic [SW-1:0] SQ_BIAS   = SW'(4);
  localparam logic [CW-1:0] TOP_BIT   = CW'(WIDTH - 1);

  state_t          state;
  logic [WIDTH-1:0] n;
  logic [DW-1:0]   d;
  logic [SW-1:0]   sq;
  logic [DW-1:0]   rem;
  logic [CW-1:0]   bit_cnt;

  logic [DW:0]     rem_shift;
  logic [DW:0]     diff;
  logic [DW-1:0]   rem_next;
  logic            sq_over;

  // Shared restoring subtract step: shift in the next candidate bit.
  always_comb begin
    rem_shift = {rem, n[bit_cnt]};
    diff      = rem_shift - {1'b0, d};
    rem_next  = diff[DW] ? rem_shift[DW-1:0] : diff[DW-1:0];
  end

  // The search is over once the divisor's square exceeds the candidate.
  assign sq_over = sq > {{(SW - WIDTH){1'b0}}, n};

  assign busy = (state != ST_IDLE);

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            n  <= candidate;
            d  <= FIRST_DIV;
            sq <= FIRST_SQ;
            if (candidate[WIDTH-1:1] == '0) begin
              // Zero and one are not prime.
              prime_flag <= 1'b0;
              done       <= 1'b1;
            end else if (candidate[WIDTH-1:2] == '0) begin
              // Two and three are prime.
              prime_flag <= 1'b1;
              done       <= 1'b1;
            end else if (!candidate[0]) begin
              // Even numbers above two are not prime.
              prime_flag <= 1'b0;
              done       <= 1'b1;
            end else begin
              state <= ST_CHECK;
            end
          end
        end
        ST_CHECK: begin
          if (sq_over) begin
            prime_flag <= 1'b1;
            done       <= 1'b1;
            state      <= ST_IDLE;
          end else begin
            rem     <= '0;
            bit_cnt <= TOP_BIT;
            state   <= ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          rem     <= rem_next;
          bit_cnt <= bit_cnt - CW'(1);
          if (bit_cnt == '0) begin
            if (rem_next == '0) begin
              // The trial divisor divides the candidate.
              prime_flag <= 1'b0;
              done       <= 1'b1;
              state      <= ST_IDLE;
            end else begin
              // Next odd divisor; (d + 2)^2 = d^2 + 4d + 4.
              d     <= d + DIV_STEP;
              sq    <= sq + SW'({d, 2'b00}) + SQ_BIAS;
              state <= ST_CHECK;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result is given only while the sequencer is idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  // An accepted command either starts the search or answers at once.
  a_start_moves: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither started nor answered");

  // The running remainder stays below the trial divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (rem < d))
    else $error("remainder not below divisor");

  // Trial divisors are odd throughout the search.
  a_div_odd: assert property (@(posedge clk) disable iff (rst)
    busy |-> d[0])
    else $error("even trial divisor");

  // An even candidate other than two is never reported prime.
  a_even_not_prime: assert property (@(posedge clk) disable iff (rst)
    (done && !n[0] && (n[WIDTH-1:2] != '0)) |-> !prime_flag)
    else $error("even candidate reported prime");

endmodule
